// ===== rtl/vcg_pkg.sv =====
// Shared types and constants for the volume central gradient block.
// No dependencies; imported by every module of the block.
`default_nettype none

package vcg_pkg;

    localparam int DEF_MAX_VOXELS = 1048576;
    localparam int DEF_MAX_DIM    = 1024;

    localparam int IDX_W      = 20;
    localparam int VOX_W      = 8;
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_CNT_W  = 21;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // register indexes on the config port
    localparam logic [1:0] REG_DIM_X        = 2'd0;
    localparam logic [1:0] REG_DIM_Y        = 2'd1;
    localparam logic [1:0] REG_VOXEL_COUNT  = 2'd2;
    localparam logic [1:0] REG_GRADS_ENABLE = 2'd3;

    localparam int FUNC_W_C = 1;
    localparam logic [FUNC_W_C-1:0] FUNC_LOAD    = 1'b0;
    localparam logic [FUNC_W_C-1:0] FUNC_COMPUTE = 1'b1;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] dim_x;
        logic [CFG_DIM_W-1:0] dim_y;
        logic [CFG_CNT_W-1:0] voxel_count;
        logic                 grads_enable;
    } cfg_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN
    } vcg_state_t;

    // (plus - minus) / 2, truncated toward zero
    function automatic logic [VOX_W-1:0] half_diff(
        input logic [VOX_W-1:0] plus,
        input logic [VOX_W-1:0] minus
    );
        logic [VOX_W:0] d;
        logic [VOX_W:0] u;
        d = {plus[VOX_W-1], plus} - {minus[VOX_W-1], minus};
        u = d + {{VOX_W{1'b0}}, d[VOX_W]};
        return u[VOX_W:1];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vcg_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on vcg_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module vcg_cfg_regs
    import vcg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_x        <= CFG_DIM_W'(256);
            cfg_reg.dim_y        <= CFG_DIM_W'(256);
            cfg_reg.voxel_count  <= CFG_CNT_W'(1048576);
            cfg_reg.grads_enable <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DIM_X:        cfg_reg.dim_x        <= pwdata[CFG_DIM_W-1:0];
                REG_DIM_Y:        cfg_reg.dim_y        <= pwdata[CFG_DIM_W-1:0];
                REG_VOXEL_COUNT:  cfg_reg.voxel_count  <= pwdata[CFG_CNT_W-1:0];
                REG_GRADS_ENABLE: cfg_reg.grads_enable <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DIM_X:        prdata = CFG_DATA_W'(cfg_reg.dim_x);
            REG_DIM_Y:        prdata = CFG_DATA_W'(cfg_reg.dim_y);
            REG_VOXEL_COUNT:  prdata = CFG_DATA_W'(cfg_reg.voxel_count);
            REG_GRADS_ENABLE: prdata = CFG_DATA_W'(cfg_reg.grads_enable);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/vcg_voxel_mem.sv =====
// Single-port voxel store, one access per cycle, registered read data.
// Depends on vcg_pkg for the voxel width and the mem_ctl_t struct.
`default_nettype none

module vcg_voxel_mem
    import vcg_pkg::*;
#(
    parameter  int DEPTH  = DEF_MAX_VOXELS,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire mem_ctl_t          ctl,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [VOX_W-1:0]  wdata,
    output logic      [VOX_W-1:0]  rdata
);

    logic [VOX_W-1:0] mem [DEPTH];
    logic [VOX_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
            mem[addr] <= wdata;
        if (ctl.re)
            rdata_reg <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/vcg_seq.sv =====
// Command sequencer: loads, the seven-read neighbour sweep and the gradient stage.
// Depends on vcg_pkg; drives the port of vcg_voxel_mem.
`default_nettype none

module vcg_seq
    import vcg_pkg::*;
#(
    parameter  int MAX_VOXELS = DEF_MAX_VOXELS,
    parameter  int MAX_DIM    = DEF_MAX_DIM,
    localparam int ADDR_W     = $clog2(MAX_VOXELS)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              start,
    input  wire logic              func,
    input  wire logic [IDX_W-1:0]  voxel_index,
    input  wire logic [VOX_W-1:0]  load_value,
    output logic                   busy,
    output mem_ctl_t               mem_ctl,
    output logic      [ADDR_W-1:0] mem_addr,
    output logic      [VOX_W-1:0]  mem_wdata,
    input  wire logic [VOX_W-1:0]  mem_rdata,
    output logic                   done,
    output logic      [VOX_W-1:0]  center_value,
    output logic      [VOX_W-1:0]  grad_x,
    output logic      [VOX_W-1:0]  grad_y,
    output logic      [VOX_W-1:0]  grad_z
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
    localparam int NW0   = $clog2(MAX_VOXELS + 1);
    localparam int NW    = (NW0 > CFG_CNT_W) ? NW0 : CFG_CNT_W;
    localparam int PW0   = (IDX_W > 2 * DIM_W) ? IDX_W : 2 * DIM_W;
    localparam int PW    = ((PW0 > NW) ? PW0 : NW) + 1;
    localparam int LW    = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

    // read order of the sweep
    localparam logic [2:0] TAG_CENTER = 3'd0;
    localparam logic [2:0] TAG_XM     = 3'd1;
    localparam logic [2:0] TAG_XP     = 3'd2;
    localparam logic [2:0] TAG_YM     = 3'd3;
    localparam logic [2:0] TAG_YP     = 3'd4;
    localparam logic [2:0] TAG_ZM     = 3'd5;
    localparam logic [2:0] TAG_ZP     = 3'd6;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    vcg_state_t state_reg, state_next;

    logic [DIM_W-1:0]   dx_reg, dy_reg;
    logic [2*DIM_W-1:0] stepz_reg;
    logic [NW-1:0]      n_reg;
    logic [DIM_W-1:0]   dx_sat, dy_sat;
    logic [NW-1:0]      n_sat;

    logic [2:0]         cnt_reg;
    logic [IDX_W-1:0]   p_reg;
    logic [2:0]         lt_reg, ge_reg;
    logic               rd_vld_reg, rd_oob_reg;
    logic [2:0]         rd_tag_reg;
    logic [VOX_W-1:0]   samp_reg [7];
    logic               done_reg;
    logic [VOX_W-1:0]   center_reg, gx_reg, gy_reg, gz_reg;

    logic               accept, accept_cmp, load_ok;
    logic [PW-1:0]      step, sum, dif, rd_addr;
    logic               is_minus, is_center, lt, ge, skip, oob;
    logic [1:0]         axis;
    logic [VOX_W-1:0]   rdata_eff;
    logic [VOX_W-1:0]   c, xm, xp, ym, yp, zm, zp;

    // config derived values, settle well before a sweep uses them
    always_comb
    begin
        dx_sat = (CW'(cfg.dim_x) > CW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cfg.dim_x);
        dy_sat = (CW'(cfg.dim_y) > CW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cfg.dim_y);
        n_sat  = (NW'(cfg.voxel_count) > NW'(MAX_VOXELS)) ? NW'(MAX_VOXELS)
                                                          : NW'(cfg.voxel_count);
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_sat;
        dy_reg    <= dy_sat;
        n_reg     <= n_sat;
        stepz_reg <= (2*DIM_W)'(dx_reg) * (2*DIM_W)'(dy_reg);
    end

    assign accept     = start && !busy;
    assign accept_cmp = accept && (func == FUNC_COMPUTE);
    assign load_ok    = LW'(voxel_index) < LW'(MAX_VOXELS);

    // neighbour address for the current sweep slot
    always_comb
    begin
        step      = '0;
        is_minus  = 1'b0;
        is_center = 1'b0;
        axis      = AX_X;
        case (cnt_reg)
            TAG_CENTER: is_center = 1'b1;
            TAG_XM:
            begin
                step     = PW'(1);
                is_minus = 1'b1;
            end
            TAG_XP: step = PW'(1);
            TAG_YM:
            begin
                step     = PW'(dx_reg);
                is_minus = 1'b1;
                axis     = AX_Y;
            end
            TAG_YP:
            begin
                step = PW'(dx_reg);
                axis = AX_Y;
            end
            TAG_ZM:
            begin
                step     = PW'(stepz_reg);
                is_minus = 1'b1;
                axis     = AX_Z;
            end
            TAG_ZP:
            begin
                step = PW'(stepz_reg);
                axis = AX_Z;
            end
            default: is_center = 1'b1;
        endcase
        sum     = PW'(p_reg) + step;
        dif     = PW'(p_reg) - step;
        lt      = PW'(p_reg) < step;
        ge      = sum >= PW'(n_reg);
        rd_addr = is_minus ? dif : sum;
        // a neighbour replaced by the centre needs no read
        skip    = is_minus ? lt : (!is_center && ge);
        oob     = rd_addr >= PW'(MAX_VOXELS);
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = (state_reg != ST_IDLE);
        mem_ctl.we = 1'b0;
        mem_ctl.re = 1'b0;
        mem_addr   = ADDR_W'(voxel_index);
        mem_wdata  = load_value;
        case (state_reg)
            ST_IDLE:
            begin
                mem_ctl.we = start && (func == FUNC_LOAD) && load_ok;
                if (accept_cmp)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                mem_addr   = ADDR_W'(rd_addr);
                mem_ctl.re = !oob && !skip;
                if (cnt_reg == TAG_ZP)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_READ);
            done_reg   <= (state_reg == ST_DRAIN);
        end
    end

    assign rdata_eff = rd_oob_reg ? '0 : mem_rdata;

    always_ff @(posedge clk)
    begin
        if (accept_cmp)
        begin
            p_reg   <= voxel_index;
            cnt_reg <= TAG_CENTER;
        end
        if (state_reg == ST_READ)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (is_minus)
                lt_reg[axis] <= lt;
            else if (!is_center)
                ge_reg[axis] <= ge;
        end
        rd_tag_reg <= cnt_reg;
        rd_oob_reg <= oob || skip;
        if (rd_vld_reg)
            samp_reg[rd_tag_reg] <= rdata_eff;
        if (state_reg == ST_DRAIN)
        begin
            center_reg <= c;
            gx_reg     <= cfg.grads_enable ? half_diff(xp, xm) : '0;
            gy_reg     <= cfg.grads_enable ? half_diff(yp, ym) : '0;
            gz_reg     <= cfg.grads_enable ? half_diff(zp, zm) : '0;
        end
    end

    // the last read of the sweep is taken straight off the memory
    always_comb
    begin
        c  = samp_reg[TAG_CENTER];
        xm = lt_reg[AX_X] ? c : samp_reg[TAG_XM];
        xp = ge_reg[AX_X] ? c : samp_reg[TAG_XP];
        ym = lt_reg[AX_Y] ? c : samp_reg[TAG_YM];
        yp = ge_reg[AX_Y] ? c : samp_reg[TAG_YP];
        zm = lt_reg[AX_Z] ? c : samp_reg[TAG_ZM];
        zp = ge_reg[AX_Z] ? c : rdata_eff;
    end

    assign done         = done_reg;
    assign center_value = center_reg;
    assign grad_x       = gx_reg;
    assign grad_y       = gy_reg;
    assign grad_z       = gz_reg;

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.we && mem_ctl.re))
        else $error("voxel store written and read in one cycle");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept_cmp |-> ##9 done_reg)
        else $error("compute transfer without result nine cycles later");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe outside idle");

    a_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg != ST_IDLE))
        else $error("read data returned outside a sweep");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.we |-> (state_reg == ST_IDLE))
        else $error("load write during a sweep");

endmodule

`default_nettype wire

// ===== rtl/volume_central_gradient.sv =====
// Top level of the volume central gradient block.
// Depends on vcg_pkg, vcg_cfg_regs, vcg_voxel_mem and vcg_seq.
//
// A load transfer (func 0) writes one voxel into the single-port store;
// busy stays low and no result follows. A compute transfer (func 1) keeps
// busy high over seven read slots of the store through its one port (centre,
// then minus and plus neighbours at steps 1, dim_x and dim_x*dim_y) and a
// drain state for the last read data. The result is registered at the end of
// the drain state and strobed on done for one cycle only, since the receiver
// cannot hold it off; a new command is taken in that same cycle.
// The store has no reset; the user must read entries only after a load wrote them.
// The user must write config registers only while idle; the block enforces neither.
`default_nettype none

module volume_central_gradient
    import vcg_pkg::*;
#(
    parameter int MAX_VOXELS = DEF_MAX_VOXELS,
    parameter int MAX_DIM    = DEF_MAX_DIM
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  func,
    input  wire logic [IDX_W-1:0]      voxel_index,
    input  wire logic [VOX_W-1:0]      load_value,
    output logic                       done,
    output logic      [VOX_W-1:0]      center_value,
    output logic      [VOX_W-1:0]      grad_x,
    output logic      [VOX_W-1:0]      grad_y,
    output logic      [VOX_W-1:0]      grad_z,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int ADDR_W = $clog2(MAX_VOXELS);

    cfg_t              cfg;
    mem_ctl_t          mem_ctl;
    logic [ADDR_W-1:0] mem_addr;
    logic [VOX_W-1:0]  mem_wdata;
    logic [VOX_W-1:0]  mem_rdata;

    vcg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vcg_voxel_mem #(
        .DEPTH (MAX_VOXELS)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    vcg_seq #(
        .MAX_VOXELS (MAX_VOXELS),
        .MAX_DIM    (MAX_DIM)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .start        (start),
        .func         (func),
        .voxel_index  (voxel_index),
        .load_value   (load_value),
        .busy         (busy),
        .mem_ctl      (mem_ctl),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata),
        .done         (done),
        .center_value (center_value),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .grad_z       (grad_z)
    );

endmodule

`default_nettype wire
